// ----- rtl/mpmc_pkg.sv -----
// ----------------------------------------------------------------------------
// mpmc_pkg
// shared constants, codes and types of the multi-pattern match counter
// ----------------------------------------------------------------------------
package mpmc_pkg;

  localparam int MaxNodes    = 4096;
  localparam int NodeW       = $clog2(MaxNodes);
  localparam int MaxPatterns = 1024;
  localparam int PatW        = $clog2(MaxPatterns);
  localparam int PatCntW     = PatW + 1;
  localparam int Alphabet    = 26;
  localparam int LetterW     = 5;
  localparam int KW          = $clog2(Alphabet);
  localparam int IndegW      = NodeW + 1;
  localparam int CntW        = 32;
  localparam int OpW         = 2;
  localparam int StatusW     = 2;

  typedef enum logic [OpW-1:0] {
    OP_PATTERN = 2'd0,
    OP_TEXT    = 2'd1,
    OP_READ    = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_NODE_FULL = 2'd1,
    ST_PAT_FULL  = 2'd2,
    ST_NOT_READY = 2'd3
  } status_e;

  typedef logic [Alphabet-1:0][NodeW-1:0] row_t;

  typedef struct packed {
    logic             re;
    logic [NodeW-1:0] ra;
    logic             we;
    logic [NodeW-1:0] wa;
    row_t             wd;
  } goto_req_t;

endpackage

// ----- rtl/mpmc_if.sv -----
// ----------------------------------------------------------------------------
// mpmc_if
// valid/ready channels for letter beats in and result beats out
// ----------------------------------------------------------------------------
interface mpmc_in_if;
  logic                         valid;
  logic                         ready;
  logic [mpmc_pkg::OpW-1:0]     opcode;
  logic [mpmc_pkg::LetterW-1:0] letter;
  logic                         last;
  logic [mpmc_pkg::PatW-1:0]    pattern_index;

  modport source (output valid, opcode, letter, last, pattern_index, input ready);
  modport sink (input valid, opcode, letter, last, pattern_index, output ready);
endinterface

interface mpmc_out_if;
  logic                         valid;
  logic                         ready;
  logic [mpmc_pkg::StatusW-1:0] status;
  logic [mpmc_pkg::PatW-1:0]    assigned_pattern;
  logic [mpmc_pkg::CntW-1:0]    occurrences;

  modport source (output valid, status, assigned_pattern, occurrences, input ready);
  modport sink (input valid, status, assigned_pattern, occurrences, output ready);
endinterface

// ----- rtl/mpmc_goto_store.sv -----
// ----------------------------------------------------------------------------
// mpmc_goto_store
// goto table, one row of child links per node; root row reads zero until
// first written
// ----------------------------------------------------------------------------
module mpmc_goto_store (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mpmc_pkg::goto_req_t   req_i,
  output mpmc_pkg::row_t        row_o
);

  mpmc_pkg::row_t mem [mpmc_pkg::MaxNodes];
  mpmc_pkg::row_t rd_q;
  logic           root_ok_q;
  logic           zero_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.wa] <= req_i.wd;
    end
    if (req_i.re) begin
      rd_q <= mem[req_i.ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_ok_q <= 1'b0;
      zero_q    <= 1'b0;
    end else begin
      if (req_i.we && req_i.wa == '0) begin
        root_ok_q <= 1'b1;
      end
      if (req_i.re) begin
        zero_q <= (req_i.ra == '0) && !root_ok_q;
      end
    end
  end

  assign row_o = zero_q ? '0 : rd_q;

endmodule

// ----- rtl/multi_pattern_match_counter.sv -----
// ----------------------------------------------------------------------------
// multi_pattern_match_counter
// aho-corasick pattern occurrence counter over a memory-held automaton
// ----------------------------------------------------------------------------
// One beat is taken at a time and answered with one result beat. The goto,
// node and pattern memories are all read through registered ports. The first
// text letter also builds the automaton in a breadth-first walk that visits
// every alphabet slot of every node, with an extra step per trie edge, and is
// bounded by the single port of the node memories. The last text letter also
// sums the counts along the failure links: it scans every node, then folds
// each node's count into its failure node. The input is ready whenever no
// beat is in work; a result waits in its own output register.
module multi_pattern_match_counter (
  input  logic        clk_i,
  input  logic        rst_ni,
  mpmc_in_if.sink     in_i,
  mpmc_out_if.source  out_o
);

  localparam int NW = mpmc_pkg::NodeW;

  typedef enum logic [1:0] {PH_LOAD, PH_TEXT, PH_DONE} phase_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_RESP,
    S_LD_ROW, S_LD_NEW,
    S_TX_ROW, S_TX_HIT,
    S_BLD_INIT, S_BLD_ROWP, S_BLD_ROWF, S_BLD_K, S_BLD_INC,
    S_BLD_POP, S_BLD_PF, S_BLD_FP,
    S_AC_SCAN, S_AC_CHK, S_AC_POP, S_AC_P, S_AC_F, S_AC_UPD,
    S_RD_END, S_RD_HIT
  } state_e;

  state_e  state_q, state_d;
  phase_e  phase_q, phase_d;
  logic [NW-1:0] cur_q, cur_d, nodes_q, nodes_d;
  logic [mpmc_pkg::PatCntW-1:0] pats_q, pats_d;
  mpmc_pkg::opcode_e op_q, op_d;
  logic [mpmc_pkg::LetterW-1:0] let_q, let_d;
  logic last_q, last_d;
  logic [mpmc_pkg::PatW-1:0] pidx_q, pidx_d;
  logic [NW-1:0] head_q, head_d, tail_q, tail_d, p_q, p_d, fp_q, fp_d;
  logic [NW-1:0] via_q, via_d, n_q, n_d, f_q, f_d;
  logic [mpmc_pkg::KW-1:0] k_q, k_d;
  logic is_root_q, is_root_d;
  mpmc_pkg::row_t rowp_q, rowp_d, rowf_q, rowf_d;
  logic [mpmc_pkg::CntW-1:0] hp_q, hp_d;
  mpmc_pkg::status_e res_st_q, res_st_d, out_st_q, out_st_d;
  logic [mpmc_pkg::PatW-1:0] res_as_q, res_as_d, out_as_q, out_as_d;
  logic [mpmc_pkg::CntW-1:0] res_oc_q, res_oc_d, out_oc_q, out_oc_d;
  logic ov_q, ov_d;

  mpmc_pkg::goto_req_t greq;
  mpmc_pkg::row_t      grow;

  logic [NW-1:0] fail_mem [mpmc_pkg::MaxNodes];
  logic [mpmc_pkg::IndegW-1:0] indeg_mem [mpmc_pkg::MaxNodes];
  logic [mpmc_pkg::CntW-1:0] hits_mem [mpmc_pkg::MaxNodes];
  logic [NW-1:0] queue_mem [mpmc_pkg::MaxNodes];
  logic [NW-1:0] pend_mem [mpmc_pkg::MaxPatterns];

  logic fail_we, fail_re, indeg_we, indeg_re, hits_we, hits_re;
  logic queue_we, queue_re, pend_we, pend_re;
  logic [NW-1:0] fail_wa, fail_ra, fail_wd, indeg_wa, indeg_ra, hits_wa, hits_ra;
  logic [NW-1:0] queue_wa, queue_ra, queue_wd, pend_wd;
  logic [mpmc_pkg::PatW-1:0] pend_wa, pend_ra;
  logic [mpmc_pkg::IndegW-1:0] indeg_wd;
  logic [mpmc_pkg::CntW-1:0] hits_wd;
  logic [NW-1:0] fail_rd_q, queue_rd_q, pend_rd_q;
  logic [mpmc_pkg::IndegW-1:0] indeg_rd_q;
  logic [mpmc_pkg::CntW-1:0] hits_rd_q;

  mpmc_goto_store u_goto (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (greq),
    .row_o  (grow)
  );

  always_ff @(posedge clk_i) begin
    if (fail_we) begin
      fail_mem[fail_wa] <= fail_wd;
    end
    if (fail_re) begin
      fail_rd_q <= fail_mem[fail_ra];
    end
    if (indeg_we) begin
      indeg_mem[indeg_wa] <= indeg_wd;
    end
    if (indeg_re) begin
      indeg_rd_q <= indeg_mem[indeg_ra];
    end
    if (hits_we) begin
      hits_mem[hits_wa] <= hits_wd;
    end
    if (hits_re) begin
      hits_rd_q <= hits_mem[hits_ra];
    end
    if (queue_we) begin
      queue_mem[queue_wa] <= queue_wd;
    end
    if (queue_re) begin
      queue_rd_q <= queue_mem[queue_ra];
    end
    if (pend_we) begin
      pend_mem[pend_wa] <= pend_wd;
    end
    if (pend_re) begin
      pend_rd_q <= pend_mem[pend_ra];
    end
  end

  always_comb begin
    logic [NW-1:0] nxt, ch, via, end_node;
    logic [mpmc_pkg::IndegW-1:0] dec;
    logic [mpmc_pkg::CntW:0] sum;
    logic do_end, adv;
    mpmc_pkg::row_t row_new;

    nxt      = grow[let_q];
    ch       = rowp_q[k_q];
    via      = is_root_q ? '0 : rowf_q[k_q];
    end_node = cur_q;
    dec      = '0;
    sum      = '0;
    do_end   = 1'b0;
    adv      = 1'b0;
    row_new  = rowp_q;

    state_d = state_q; phase_d = phase_q; cur_d = cur_q; nodes_d = nodes_q;
    pats_d = pats_q; op_d = op_q; let_d = let_q; last_d = last_q; pidx_d = pidx_q;
    head_d = head_q; tail_d = tail_q; p_d = p_q; fp_d = fp_q; via_d = via_q;
    n_d = n_q; f_d = f_q; k_d = k_q; is_root_d = is_root_q;
    rowp_d = rowp_q; rowf_d = rowf_q; hp_d = hp_q;
    res_st_d = res_st_q; res_as_d = res_as_q; res_oc_d = res_oc_q;
    out_st_d = out_st_q; out_as_d = out_as_q; out_oc_d = out_oc_q;
    ov_d = ov_q && !out_o.ready;

    greq = '0;
    fail_we = 1'b0; fail_re = 1'b0; fail_wa = '0; fail_ra = '0; fail_wd = '0;
    indeg_we = 1'b0; indeg_re = 1'b0; indeg_wa = '0; indeg_ra = '0; indeg_wd = '0;
    hits_we = 1'b0; hits_re = 1'b0; hits_wa = '0; hits_ra = '0; hits_wd = '0;
    queue_we = 1'b0; queue_re = 1'b0; queue_wa = '0; queue_ra = '0; queue_wd = '0;
    pend_we = 1'b0; pend_re = 1'b0; pend_wa = '0; pend_ra = '0; pend_wd = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d     = mpmc_pkg::opcode_e'(in_i.opcode);
          let_d    = in_i.letter;
          last_d   = in_i.last;
          pidx_d   = in_i.pattern_index;
          res_st_d = mpmc_pkg::ST_OK;
          res_as_d = '0;
          res_oc_d = '0;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_RESP;
        if (op_q == mpmc_pkg::OP_PATTERN && phase_q == PH_LOAD &&
            let_q < mpmc_pkg::LetterW'(mpmc_pkg::Alphabet)) begin
          greq.re = 1'b1;
          greq.ra = cur_q;
          state_d = S_LD_ROW;
        end else if (op_q == mpmc_pkg::OP_TEXT && phase_q != PH_DONE &&
                     let_q < mpmc_pkg::LetterW'(mpmc_pkg::Alphabet)) begin
          if (phase_q == PH_LOAD) begin
            state_d = S_BLD_INIT;
          end else begin
            greq.re = 1'b1;
            greq.ra = cur_q;
            state_d = S_TX_ROW;
          end
        end else if (op_q == mpmc_pkg::OP_READ) begin
          if (phase_q != PH_DONE) begin
            res_st_d = mpmc_pkg::ST_NOT_READY;
          end else if ({1'b0, pidx_q} < pats_q) begin
            pend_re = 1'b1;
            pend_ra = pidx_q;
            state_d = S_RD_END;
          end
        end
      end
      S_LD_ROW: begin
        if (nxt != '0) begin
          end_node = nxt;
          cur_d    = nxt;
          do_end   = 1'b1;
        end else if (nodes_q == NW'(mpmc_pkg::MaxNodes - 1)) begin
          res_st_d = mpmc_pkg::ST_NODE_FULL;
          if (last_q) begin
            cur_d = '0;
          end
          state_d = S_RESP;
        end else begin
          greq.we = 1'b1;
          greq.wa = cur_q;
          greq.wd = grow;
          greq.wd[let_q] = nodes_q + 1'b1;
          nodes_d  = nodes_q + 1'b1;
          cur_d    = nodes_q + 1'b1;
          hits_we  = 1'b1;
          hits_wa  = nodes_q + 1'b1;
          indeg_we = 1'b1;
          indeg_wa = nodes_q + 1'b1;
          state_d  = S_LD_NEW;
        end
      end
      S_LD_NEW: begin
        greq.we = 1'b1;
        greq.wa = cur_q;
        do_end  = 1'b1;
      end
      S_TX_ROW: begin
        cur_d   = nxt;
        hits_re = 1'b1;
        hits_ra = nxt;
        state_d = S_TX_HIT;
      end
      S_TX_HIT: begin
        hits_we = 1'b1;
        hits_wa = cur_q;
        hits_wd = (hits_rd_q == '1) ? hits_rd_q : hits_rd_q + 1'b1;
        if (last_q) begin
          n_d    = NW'(1);
          head_d = '0;
          tail_d = '0;
          state_d = (nodes_q == '0) ? S_AC_POP : S_AC_SCAN;
        end else begin
          state_d = S_RESP;
        end
      end
      S_BLD_INIT: begin
        hits_we   = 1'b1;
        indeg_we  = 1'b1;
        head_d    = '0;
        tail_d    = '0;
        p_d       = '0;
        is_root_d = 1'b1;
        k_d       = '0;
        greq.re   = 1'b1;
        state_d   = S_BLD_ROWP;
      end
      S_BLD_ROWP: begin
        rowp_d = grow;
        if (is_root_q) begin
          state_d = S_BLD_K;
        end else begin
          greq.re = 1'b1;
          greq.ra = fp_q;
          state_d = S_BLD_ROWF;
        end
      end
      S_BLD_ROWF: begin
        rowf_d  = grow;
        state_d = S_BLD_K;
      end
      S_BLD_K: begin
        if (ch != '0) begin
          fail_we  = 1'b1;
          fail_wa  = ch;
          fail_wd  = via;
          queue_we = 1'b1;
          queue_wa = tail_q;
          queue_wd = ch;
          tail_d   = tail_q + 1'b1;
          indeg_re = 1'b1;
          indeg_ra = via;
          via_d    = via;
          state_d  = S_BLD_INC;
        end else begin
          row_new[k_q] = via;
          rowp_d = row_new;
          adv    = 1'b1;
        end
      end
      S_BLD_INC: begin
        indeg_we = 1'b1;
        indeg_wa = via_q;
        indeg_wd = indeg_rd_q + 1'b1;
        adv      = 1'b1;
        state_d  = S_BLD_K;
      end
      S_BLD_POP: begin
        if (head_q < tail_q) begin
          queue_re = 1'b1;
          queue_ra = head_q;
          head_d   = head_q + 1'b1;
          state_d  = S_BLD_PF;
        end else begin
          phase_d = PH_TEXT;
          cur_d   = '0;
          greq.re = 1'b1;
          state_d = S_TX_ROW;
        end
      end
      S_BLD_PF: begin
        p_d     = queue_rd_q;
        fail_re = 1'b1;
        fail_ra = queue_rd_q;
        state_d = S_BLD_FP;
      end
      S_BLD_FP: begin
        fp_d      = fail_rd_q;
        is_root_d = 1'b0;
        k_d       = '0;
        greq.re   = 1'b1;
        greq.ra   = p_q;
        state_d   = S_BLD_ROWP;
      end
      S_AC_SCAN: begin
        indeg_re = 1'b1;
        indeg_ra = n_q;
        state_d  = S_AC_CHK;
      end
      S_AC_CHK: begin
        if (indeg_rd_q == '0) begin
          queue_we = 1'b1;
          queue_wa = tail_q;
          queue_wd = n_q;
          tail_d   = tail_q + 1'b1;
        end
        n_d     = n_q + 1'b1;
        state_d = (n_q == nodes_q) ? S_AC_POP : S_AC_SCAN;
      end
      S_AC_POP: begin
        if (head_q < tail_q) begin
          queue_re = 1'b1;
          queue_ra = head_q;
          head_d   = head_q + 1'b1;
          state_d  = S_AC_P;
        end else begin
          phase_d = PH_DONE;
          state_d = S_RESP;
        end
      end
      S_AC_P: begin
        fail_re = 1'b1;
        fail_ra = queue_rd_q;
        hits_re = 1'b1;
        hits_ra = queue_rd_q;
        state_d = S_AC_F;
      end
      S_AC_F: begin
        f_d      = fail_rd_q;
        hp_d     = hits_rd_q;
        hits_re  = 1'b1;
        hits_ra  = fail_rd_q;
        indeg_re = 1'b1;
        indeg_ra = fail_rd_q;
        state_d  = S_AC_UPD;
      end
      S_AC_UPD: begin
        sum      = {1'b0, hits_rd_q} + {1'b0, hp_q};
        dec      = (indeg_rd_q != '0) ? indeg_rd_q - 1'b1 : '0;
        hits_we  = 1'b1;
        hits_wa  = f_q;
        hits_wd  = sum[mpmc_pkg::CntW] ? '1 : sum[mpmc_pkg::CntW-1:0];
        indeg_we = 1'b1;
        indeg_wa = f_q;
        indeg_wd = dec;
        if (f_q != '0 && dec == '0) begin
          queue_we = 1'b1;
          queue_wa = tail_q;
          queue_wd = f_q;
          tail_d   = tail_q + 1'b1;
        end
        state_d = S_AC_POP;
      end
      S_RD_END: begin
        hits_re = 1'b1;
        hits_ra = pend_rd_q;
        state_d = S_RD_HIT;
      end
      S_RD_HIT: begin
        res_oc_d = hits_rd_q;
        state_d  = S_RESP;
      end
      S_RESP: begin
        if (!ov_q || out_o.ready) begin
          ov_d     = 1'b1;
          out_st_d = res_st_q;
          out_as_d = res_as_q;
          out_oc_d = res_oc_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // end of a pattern letter that reached a node
    if (do_end) begin
      if (last_q) begin
        if (pats_q == mpmc_pkg::PatCntW'(mpmc_pkg::MaxPatterns)) begin
          res_st_d = mpmc_pkg::ST_PAT_FULL;
        end else begin
          pend_we  = 1'b1;
          pend_wa  = pats_q[mpmc_pkg::PatW-1:0];
          pend_wd  = end_node;
          res_as_d = pats_q[mpmc_pkg::PatW-1:0];
          pats_d   = pats_q + 1'b1;
        end
        cur_d = '0;
      end
      state_d = S_RESP;
    end

    // step to the next alphabet slot, write back the finished row
    if (adv) begin
      if (k_q == mpmc_pkg::KW'(mpmc_pkg::Alphabet - 1)) begin
        if (!is_root_q) begin
          greq.we = 1'b1;
          greq.wa = p_q;
          greq.wd = row_new;
        end
        state_d = S_BLD_POP;
      end else begin
        k_d     = k_q + 1'b1;
        state_d = S_BLD_K;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;    phase_q <= PH_LOAD;  cur_q <= '0;    nodes_q <= '0;
      pats_q <= '0;         op_q <= mpmc_pkg::OP_NONE; let_q <= '0;  last_q <= 1'b0;
      pidx_q <= '0;         head_q <= '0;        tail_q <= '0;   p_q <= '0;
      fp_q <= '0;           via_q <= '0;         n_q <= '0;      f_q <= '0;
      k_q <= '0;            is_root_q <= 1'b0;   rowp_q <= '0;   rowf_q <= '0;
      hp_q <= '0;           res_st_q <= mpmc_pkg::ST_OK; res_as_q <= '0;
      res_oc_q <= '0;       out_st_q <= mpmc_pkg::ST_OK; out_as_q <= '0;
      out_oc_q <= '0;       ov_q <= 1'b0;
    end else begin
      state_q <= state_d;   phase_q <= phase_d;  cur_q <= cur_d; nodes_q <= nodes_d;
      pats_q <= pats_d;     op_q <= op_d;        let_q <= let_d; last_q <= last_d;
      pidx_q <= pidx_d;     head_q <= head_d;    tail_q <= tail_d; p_q <= p_d;
      fp_q <= fp_d;         via_q <= via_d;      n_q <= n_d;     f_q <= f_d;
      k_q <= k_d;           is_root_q <= is_root_d; rowp_q <= rowp_d; rowf_q <= rowf_d;
      hp_q <= hp_d;         res_st_q <= res_st_d; res_as_q <= res_as_d;
      res_oc_q <= res_oc_d; out_st_q <= out_st_d; out_as_q <= out_as_d;
      out_oc_q <= out_oc_d; ov_q <= ov_d;
    end
  end

  assign in_i.ready             = (state_q == S_IDLE);
  assign out_o.valid            = ov_q;
  assign out_o.status           = out_st_q;
  assign out_o.assigned_pattern = out_as_q;
  assign out_o.occurrences      = out_oc_q;

endmodule
